>>> hdl/oneshot_periodic_event_timer_defines.svh
// Assertion macros for the event timer block.
`ifndef ONESHOT_PERIODIC_EVENT_TIMER_DEFINES_SVH
`define ONESHOT_PERIODIC_EVENT_TIMER_DEFINES_SVH
`ifndef SYNTHESIS
`define OPET_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OPET_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define OPET_ASSERT(label, clk, rst_n, prop, msg)
`define OPET_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

>>> hdl/opet_pkg.sv
// Package: types, codes and sizes of the event timer block.
`default_nettype none
package opet_pkg;
  localparam int unsigned OneshotSlots  = 16;
  localparam int unsigned PeriodicSlots = 16;
  localparam int unsigned MaxFires      = 32;
  localparam int unsigned OsIdxW = (OneshotSlots > 1) ? $clog2(OneshotSlots) : 1;
  localparam int unsigned PrIdxW = (PeriodicSlots > 1) ? $clog2(PeriodicSlots) : 1;
  localparam int unsigned FireCntW = $clog2(MaxFires + 1);

  localparam logic [2:0] CmdProcess   = 3'd0;
  localparam logic [2:0] CmdAddOnce   = 3'd1;
  localparam logic [2:0] CmdAddPeriod = 3'd2;
  localparam logic [2:0] CmdDelOnce   = 3'd3;
  localparam logic [2:0] CmdDelPeriod = 3'd4;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StFull    = 3'd1;
  localparam logic [2:0] StMissing = 3'd2;
  localparam logic [2:0] StFired   = 3'd3;
  localparam logic [2:0] StNone    = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] delay_or_deadline;
    logic [15:0] period_ms;
    logic [7:0]  event_id;
    logic [15:0] elapsed_ms;
  } opet_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  fired_id;
    logic        fired_periodic;
    logic [31:0] fired_deadline;
    logic        last;
  } opet_rsp_t;

  // one candidate seen by the shared compare unit
  typedef struct packed {
    logic        ok;
    logic [31:0] due;
    logic [15:0] age;
  } opet_cand_t;
endpackage
`default_nettype wire

>>> hdl/opet_pick.sv
// Shared compare unit: keeps the earliest-due, oldest expired candidate of a scan.
`default_nettype none
module opet_pick import opet_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        clear_i,
  input  wire logic        step_i,
  input  wire opet_cand_t  cand_i,
  input  wire logic [4:0]  idx_i,
  output logic             found_o,
  output logic [4:0]       idx_o
);
  logic        found_q;
  logic [31:0] due_q;
  logic [15:0] age_q;
  logic [4:0]  idx_q;
  logic        better;

  assign better = cand_i.ok && (!found_q || cand_i.due < due_q ||
                  (cand_i.due == due_q && cand_i.age > age_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clear_i) begin
      found_q <= 1'b0;
    end else if (step_i && better) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && better) begin
      due_q <= cand_i.due;
      age_q <= cand_i.age;
      idx_q <= idx_i;
    end
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;
endmodule
`default_nettype wire

>>> hdl/oneshot_periodic_event_timer.sv
// Top level: millisecond clock with one-shot and periodic timer tables.
// Add, delete and unknown commands end in S_REPLY; strobe then follows through the strobe_q register.
// Process: each pass scans one table and fires at most one timer; one pass per fire
// plus one closing pass per table, with at most MaxFires = 32 fires; one slot compare per cycle.
// One transaction at a time, no receiver stall; reset empties tables, clears clock/counter.
`default_nettype none
`include "oneshot_periodic_event_timer_defines.svh"
module oneshot_periodic_event_timer import opet_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire opet_req_t req_i,
  output logic           strobe,
  output opet_rsp_t      rsp_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_OS, S_FIRE_OS, S_SCAN_PR, S_FIRE_PR, S_SEARCH, S_REPLY
  } state_e;

  state_e      state_q;
  opet_req_t   req_q;
  logic [31:0] now_q;
  logic [15:0] ins_q;
  logic [5:0]  ptr_q;
  logic [FireCntW-1:0] fires_q;
  logic        hit_q;
  logic [2:0]  reply_st_q;
  logic        strobe_q;
  opet_rsp_t   rsp_q;

  logic [OneshotSlots-1:0]  os_valid_q, os_done_q;
  logic [31:0] os_due_q   [OneshotSlots];
  logic [7:0]  os_evt_q   [OneshotSlots];
  logic [15:0] os_stamp_q [OneshotSlots];
  logic [PeriodicSlots-1:0] pr_valid_q, pr_done_q;
  logic [31:0] pr_due_q   [PeriodicSlots];
  logic [15:0] pr_int_q   [PeriodicSlots];
  logic [7:0]  pr_evt_q   [PeriodicSlots];
  logic [15:0] pr_stamp_q [PeriodicSlots];

  logic [OsIdxW-1:0] os_i;
  logic [PrIdxW-1:0] pr_i;
  opet_cand_t  cand;
  logic        pick_clear, pick_step, found;
  logic [4:0]  pick_idx;
  logic [OsIdxW-1:0] os_pick;
  logic [PrIdxW-1:0] pr_pick;
  logic        accept;
  logic        fire_go;
  logic        pend_q;
  opet_rsp_t   pend_rsp_q;
  logic        flush;

  assign accept  = start && !busy;
  assign fire_go = found && fires_q != FireCntW'(MaxFires);
  assign os_i    = ptr_q[OsIdxW-1:0];
  assign pr_i    = ptr_q[PrIdxW-1:0];
  assign os_pick = pick_idx[OsIdxW-1:0];
  assign pr_pick = pick_idx[PrIdxW-1:0];

  always_comb begin
    cand = '0;
    if (state_q == S_SCAN_OS && ptr_q < 6'(OneshotSlots)) begin
      cand.ok  = os_valid_q[os_i] && !os_done_q[os_i] && (os_due_q[os_i] < now_q);
      cand.due = os_due_q[os_i];
      cand.age = ins_q - os_stamp_q[os_i];
    end else if (state_q == S_SCAN_PR && ptr_q < 6'(PeriodicSlots)) begin
      cand.ok  = pr_valid_q[pr_i] && !pr_done_q[pr_i] && (pr_due_q[pr_i] < now_q);
      cand.due = pr_due_q[pr_i];
      cand.age = ins_q - pr_stamp_q[pr_i];
    end
  end

  assign pick_step = (state_q == S_SCAN_OS) || (state_q == S_SCAN_PR);

  opet_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (pick_clear),
    .step_i  (pick_step),
    .cand_i  (cand),
    .idx_i   (ptr_q[4:0]),
    .found_o (found),
    .idx_o   (pick_idx)
  );

  assign pick_clear = (state_q == S_FIRE_OS) || (state_q == S_FIRE_PR) ||
                      (state_q == S_IDLE);

  // a process that fired ends by marking its last fire instead of a status reply
  assign flush = (state_q == S_REPLY) && reply_st_q == StNone && fires_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= ((state_q == S_FIRE_OS || state_q == S_FIRE_PR) && fire_go) ||
                  (state_q == S_REPLY && !flush);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      now_q        <= '0;
      ins_q        <= '0;
      ptr_q        <= '0;
      fires_q      <= '0;
      hit_q        <= 1'b0;
      reply_st_q   <= StOk;
      rsp_q        <= '0;
      os_valid_q   <= '0;
      os_done_q    <= '0;
      pr_valid_q   <= '0;
      pr_done_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ptr_q   <= '0;
            hit_q   <= 1'b0;
            fires_q <= '0;
            os_done_q <= '0;
            pr_done_q <= '0;
            priority if (req_i.cmd == CmdProcess) begin
              now_q   <= now_q + 32'(req_i.elapsed_ms);
              state_q <= S_SCAN_OS;
            end else if (req_i.cmd == CmdAddOnce || req_i.cmd == CmdAddPeriod ||
                         req_i.cmd == CmdDelOnce || req_i.cmd == CmdDelPeriod) begin
              state_q <= S_SEARCH;
            end else begin
              reply_st_q <= StOk;
              state_q    <= S_REPLY;
            end
          end
        end
        S_SCAN_OS: begin
          // the extra step at ptr == table size lets the last compare land
          if (ptr_q == 6'(OneshotSlots)) begin
            state_q <= S_FIRE_OS;
          end else begin
            ptr_q <= ptr_q + 6'd1;
          end
        end
        S_FIRE_OS: begin
          ptr_q <= '0;
          if (fire_go) begin
            os_done_q[os_pick]  <= 1'b1;
            os_valid_q[os_pick] <= 1'b0;
            fires_q  <= fires_q + FireCntW'(1);
            rsp_q    <= '{StFired, os_evt_q[os_pick], 1'b0, os_due_q[os_pick], 1'b0};
            state_q  <= S_SCAN_OS;
          end else begin
            state_q <= S_SCAN_PR;
          end
        end
        S_SCAN_PR: begin
          if (ptr_q == 6'(PeriodicSlots)) begin
            state_q <= S_FIRE_PR;
          end else begin
            ptr_q <= ptr_q + 6'd1;
          end
        end
        S_FIRE_PR: begin
          ptr_q <= '0;
          if (fire_go) begin
            pr_done_q[pr_pick]  <= 1'b1;
            pr_due_q[pr_pick]   <= now_q + 32'(pr_int_q[pr_pick]);
            pr_stamp_q[pr_pick] <= ins_q;
            ins_q    <= ins_q + 16'd1;
            fires_q  <= fires_q + FireCntW'(1);
            rsp_q    <= '{StFired, pr_evt_q[pr_pick], 1'b1, pr_due_q[pr_pick], 1'b0};
            state_q  <= S_SCAN_PR;
          end else begin
            reply_st_q <= StNone;
            state_q    <= S_REPLY;
          end
        end
        S_SEARCH: begin
          // walk slots: first free for adds, matches for deletes
          priority if (req_q.cmd == CmdAddOnce) begin
            if (ptr_q == 6'(OneshotSlots)) begin
              reply_st_q <= StFull;
              state_q    <= S_REPLY;
            end else if (!os_valid_q[os_i]) begin
              os_valid_q[os_i] <= 1'b1;
              os_due_q[os_i]   <= now_q + req_q.delay_or_deadline;
              os_evt_q[os_i]   <= req_q.event_id;
              os_stamp_q[os_i] <= ins_q;
              ins_q      <= ins_q + 16'd1;
              reply_st_q <= StOk;
              state_q    <= S_REPLY;
            end else begin
              ptr_q <= ptr_q + 6'd1;
            end
          end else if (req_q.cmd == CmdAddPeriod) begin
            if (ptr_q == 6'(PeriodicSlots)) begin
              reply_st_q <= StFull;
              state_q    <= S_REPLY;
            end else if (!pr_valid_q[pr_i]) begin
              pr_valid_q[pr_i] <= 1'b1;
              pr_due_q[pr_i]   <= now_q + req_q.delay_or_deadline;
              pr_int_q[pr_i]   <= req_q.period_ms;
              pr_evt_q[pr_i]   <= req_q.event_id;
              pr_stamp_q[pr_i] <= ins_q;
              ins_q      <= ins_q + 16'd1;
              reply_st_q <= StOk;
              state_q    <= S_REPLY;
            end else begin
              ptr_q <= ptr_q + 6'd1;
            end
          end else if (req_q.cmd == CmdDelOnce) begin
            if (ptr_q == 6'(OneshotSlots)) begin
              reply_st_q <= hit_q ? StOk : StMissing;
              state_q    <= S_REPLY;
            end else begin
              if (os_valid_q[os_i] && os_due_q[os_i] == req_q.delay_or_deadline &&
                  os_evt_q[os_i] == req_q.event_id) begin
                os_valid_q[os_i] <= 1'b0;
                hit_q <= 1'b1;
              end
              ptr_q <= ptr_q + 6'd1;
            end
          end else begin
            if (ptr_q == 6'(PeriodicSlots)) begin
              reply_st_q <= hit_q ? StOk : StMissing;
              state_q    <= S_REPLY;
            end else begin
              if (pr_valid_q[pr_i] && pr_int_q[pr_i] == req_q.period_ms &&
                  pr_evt_q[pr_i] == req_q.event_id) begin
                pr_valid_q[pr_i] <= 1'b0;
                hit_q <= 1'b1;
              end
              ptr_q <= ptr_q + 6'd1;
            end
          end
        end
        S_REPLY: begin
          rsp_q   <= '{reply_st_q, 8'd0, 1'b0, 32'd0, 1'b1};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept) begin
      req_q <= req_i;
    end
  end

  // Hold each fire in pend_rsp_q until the next fire or the flush, so the last one can carry last=1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      strobe <= 1'b0;
    end else begin
      if (strobe_q && rsp_q.status == StFired) begin
        pend_q <= 1'b1;
        strobe <= pend_q;
      end else if (flush) begin
        pend_q <= 1'b0;
        strobe <= 1'b1;
      end else begin
        strobe <= strobe_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (strobe_q && rsp_q.status == StFired) begin
      pend_rsp_q <= rsp_q;
      rsp_o      <= pend_rsp_q;
    end else if (flush) begin
      rsp_o      <= '{pend_rsp_q.status, pend_rsp_q.fired_id,
                      pend_rsp_q.fired_periodic, pend_rsp_q.fired_deadline, 1'b1};
    end else if (strobe_q) begin
      rsp_o <= rsp_q;
    end
  end

  assign busy = (state_q != S_IDLE) || strobe_q || pend_q;

  `OPET_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy,
                    "accepted transaction did not raise busy")
  `OPET_ASSERT(a_fire_cap, clk_i, rst_ni, fires_q <= FireCntW'(MaxFires),
               "fire count above cap")
  `OPET_ASSERT(a_done_valid, clk_i, rst_ni, (os_done_q & os_valid_q) == '0,
               "fired one-shot still armed")
endmodule
`default_nettype wire
